FILE: rtl/pifmt_pkg.sv
// ----------------------------------------------------------------------------
// pifmt_pkg
// Shared types and constants of the printf integer field formatter: the
// conversion kind codes, emit phase codes and the command and status groups
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pifmt_pkg;

	// Conversion kinds as they arrive on conv_kind.
	localparam logic [2:0] KIND_SDEC = 3'd0;
	localparam logic [2:0] KIND_UDEC = 3'd1;
	localparam logic [2:0] KIND_HEX  = 3'd2;
	localparam logic [2:0] KIND_UHEX = 3'd3;
	localparam logic [2:0] KIND_OCT  = 3'd4;
	localparam logic [2:0] KIND_BIN  = 3'd5;
	localparam logic [2:0] KIND_CHAR = 3'd6;
	localparam logic [2:0] KIND_PTR  = 3'd7;

	// Emit phases, in the order the field is written.
	localparam logic [2:0] PH_LPAD = 3'd0;
	localparam logic [2:0] PH_PFX  = 3'd1;
	localparam logic [2:0] PH_ZPAD = 3'd2;
	localparam logic [2:0] PH_DIG  = 3'd3;
	localparam logic [2:0] PH_RPAD = 3'd4;

	// Width of the field length, count and width values.
	localparam int LEN_W = 7;

	typedef struct packed {
		logic       load;      // capture a new conversion
		logic       dabble;    // one binary to BCD step
		logic       trim;      // drop one leading zero digit
		logic       setup;     // work out padding and field length
		logic       cnt_load;  // load the phase counter for phase
		logic       emit;      // write one character of phase
		logic [2:0] phase;
	} pifmt_cmd_t;

	typedef struct packed {
		logic is_dec;       // decimal conversion, needs BCD steps
		logic dabble_last;  // the final BCD step is under way
		logic trim_done;    // no leading zero digit left to drop
		logic cnt_zero;     // current phase has nothing left to write
		logic at_last;      // next character written ends the field
	} pifmt_stat_t;

endpackage

FILE: rtl/pifmt_dp.sv
// ----------------------------------------------------------------------------
// pifmt_dp
// Datapath of the formatter: operand capture, shift-and-add-3 binary to BCD
// conversion, leading zero removal, padding arithmetic and the output
// character register.
// ----------------------------------------------------------------------------
module pifmt_dp #(
	parameter int MAX_FIELD_CHARS = 64
) (
	input  logic                    clk,
	input  logic [63:0]             value,
	input  logic [2:0]              conv_kind,
	input  logic                    long_arg,
	input  logic                    alt_form,
	input  logic                    zero_fill,
	input  logic                    left_justify,
	input  logic                    blank_sign,
	input  logic                    plus_sign,
	input  logic [6:0]              min_width,
	input  pifmt_pkg::pifmt_cmd_t   cmd,
	output pifmt_pkg::pifmt_stat_t  st,
	output logic [7:0]              out_char,
	output logic                    last_char
);
	import pifmt_pkg::*;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_HEX = 2'd1;
	localparam logic [1:0] BASE_OCT = 2'd2;
	localparam logic [1:0] BASE_BIN = 2'd3;

	localparam int NUM_W = 80;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD_CHARS);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic up);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'b0, d};
		end else begin
			r = (up ? CH_UP_A : CH_LOW_A) + {4'b0, d} - 8'd10;
		end
		return r;
	endfunction

	// Captured conversion.
	logic [1:0]       base_q;
	logic             upper_q;
	logic             is_char_q;
	logic             ljust_q;
	logic             zpad_en_q;
	logic [LEN_W-1:0] width_q;
	logic [7:0]       pfx0_q;
	logic [7:0]       pfx1_q;
	logic [1:0]       plen_q;

	// Working registers.
	logic [NUM_W-1:0] num_q;
	logic [63:0]      mag_q;
	logic [5:0]       step_q;
	logic [LEN_W-1:0] ndig_q;
	logic [LEN_W-1:0] pad_q;
	logic [LEN_W-1:0] len_m1_q;
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] ocnt_q;
	logic [7:0]       out_char_q;
	logic             last_q;

	// Load decode.
	logic [63:0]      ld_val;
	logic [63:0]      ld_sext;
	logic [63:0]      ld_mag;
	logic             ld_alt;
	logic [1:0]       ld_base;
	logic             ld_upper;
	logic             ld_char;
	logic [LEN_W-1:0] ld_ndig;
	logic [7:0]       ld_pfx0;
	logic [7:0]       ld_pfx1;
	logic [1:0]       ld_plen;
	logic [NUM_W-1:0] ld_num;

	always_comb begin
		ld_alt   = alt_form || (conv_kind == KIND_PTR);
		ld_val   = (long_arg || conv_kind == KIND_PTR) ? value : {32'b0, value[31:0]};
		ld_sext  = long_arg ? value : {{32{value[31]}}, value[31:0]};
		ld_mag   = ld_val;
		ld_base  = BASE_HEX;
		ld_upper = 1'b0;
		ld_char  = 1'b0;
		ld_ndig  = LEN_W'(16);
		ld_pfx0  = CH_ZERO;
		ld_pfx1  = CH_LOW_X;
		ld_plen  = 2'd0;
		case (conv_kind)
			KIND_SDEC: begin
				ld_base = BASE_DEC;
				ld_ndig = LEN_W'(20);
				if (ld_sext[63]) begin
					ld_mag  = 64'd0 - ld_sext;
					ld_pfx0 = CH_MINUS;
					ld_plen = 2'd1;
				end else begin
					ld_mag = ld_sext;
					if (blank_sign) begin
						ld_pfx0 = CH_SPACE;
						ld_plen = 2'd1;
					end else if (plus_sign) begin
						ld_pfx0 = CH_PLUS;
						ld_plen = 2'd1;
					end
				end
			end
			KIND_UDEC: begin
				ld_base = BASE_DEC;
				ld_ndig = LEN_W'(20);
				if (blank_sign) begin
					ld_pfx0 = CH_SPACE;
					ld_plen = 2'd1;
				end else if (plus_sign) begin
					ld_pfx0 = CH_PLUS;
					ld_plen = 2'd1;
				end
			end
			KIND_HEX, KIND_PTR: begin
				if (ld_alt) ld_plen = 2'd2;
			end
			KIND_UHEX: begin
				ld_upper = 1'b1;
				if (ld_alt) ld_plen = 2'd2;
			end
			KIND_OCT: begin
				ld_base = BASE_OCT;
				ld_ndig = LEN_W'(22);
				if (ld_alt) ld_plen = 2'd1;
			end
			KIND_BIN: begin
				ld_base = BASE_BIN;
				ld_ndig = LEN_W'(64);
				ld_pfx1 = CH_LOW_B;
				if (ld_alt) ld_plen = 2'd2;
			end
			KIND_CHAR: begin
				ld_char = 1'b1;
				ld_ndig = LEN_W'(1);
			end
			default: begin
			end
		endcase
		// Digits sit left-aligned so the leading digit is always at the top.
		case (ld_base)
			BASE_DEC: ld_num = '0;
			BASE_OCT: ld_num = {2'b0, ld_mag, 14'b0};
			default:  ld_num = {ld_mag, 16'b0};
		endcase
		if (ld_char) ld_num = {value[7:0], 72'b0};
	end

	// Leading digit and the register shifted past it.
	logic [3:0]       top_dig;
	logic [NUM_W-1:0] num_shl;

	always_comb begin
		case (base_q)
			BASE_OCT: begin
				top_dig = {1'b0, num_q[NUM_W-1 -: 3]};
				num_shl = num_q << 3;
			end
			BASE_BIN: begin
				top_dig = {3'b0, num_q[NUM_W-1]};
				num_shl = num_q << 1;
			end
			default: begin
				top_dig = num_q[NUM_W-1 -: 4];
				num_shl = num_q << 4;
			end
		endcase
	end

	// Add-3 correction on every BCD digit before the shift.
	logic [NUM_W-1:0] bcd_adj;

	always_comb begin
		for (int i = 0; i < NUM_W / 4; i++) begin
			bcd_adj[i*4 +: 4] = (num_q[i*4 +: 4] >= 4'd5) ? num_q[i*4 +: 4] + 4'd3
			                                               : num_q[i*4 +: 4];
		end
	end

	// Padding arithmetic.
	logic [LEN_W-1:0] total;
	logic [LEN_W-1:0] pad_c;
	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] len_cap;

	always_comb begin
		total   = ndig_q + {{(LEN_W-2){1'b0}}, plen_q};
		pad_c   = (width_q > total) ? width_q - total : '0;
		len_c   = (width_q > total) ? width_q : total;
		len_cap = (len_c > MAX_LEN) ? MAX_LEN : len_c;
	end

	// Phase counter preset and character of the current phase.
	logic [LEN_W-1:0] cnt_init;
	logic [7:0]       ch;

	always_comb begin
		case (cmd.phase)
			PH_LPAD: cnt_init = (!ljust_q && !zpad_en_q) ? pad_q : '0;
			PH_PFX:  cnt_init = {{(LEN_W-2){1'b0}}, plen_q};
			PH_ZPAD: cnt_init = zpad_en_q ? pad_q : '0;
			PH_DIG:  cnt_init = ndig_q;
			PH_RPAD: cnt_init = ljust_q ? pad_q : '0;
			default: cnt_init = '0;
		endcase
		case (cmd.phase)
			PH_PFX:  ch = (cnt_q == {{(LEN_W-2){1'b0}}, plen_q}) ? pfx0_q : pfx1_q;
			PH_ZPAD: ch = CH_ZERO;
			PH_DIG:  ch = is_char_q ? num_q[NUM_W-1 -: 8] : digit_ascii(top_dig, upper_q);
			default: ch = CH_SPACE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q    <= ld_base;
			upper_q   <= ld_upper;
			is_char_q <= ld_char;
			ljust_q   <= left_justify;
			zpad_en_q <= zero_fill && !left_justify && !ld_char;
			width_q   <= min_width;
			pfx0_q    <= ld_pfx0;
			pfx1_q    <= ld_pfx1;
			plen_q    <= ld_plen;
			num_q     <= ld_num;
			mag_q     <= ld_mag;
			step_q    <= '0;
			ndig_q    <= ld_ndig;
			ocnt_q    <= '0;
		end
		if (cmd.dabble) begin
			num_q  <= {bcd_adj[NUM_W-2:0], mag_q[63]};
			mag_q  <= mag_q << 1;
			step_q <= step_q + 6'd1;
		end
		if (cmd.trim) begin
			num_q  <= num_shl;
			ndig_q <= ndig_q - LEN_W'(1);
		end
		if (cmd.setup) begin
			pad_q    <= pad_c;
			len_m1_q <= len_cap - LEN_W'(1);
		end
		if (cmd.cnt_load) begin
			cnt_q <= cnt_init;
		end
		if (cmd.emit) begin
			out_char_q <= ch;
			last_q     <= (ocnt_q == len_m1_q);
			cnt_q      <= cnt_q - LEN_W'(1);
			ocnt_q     <= ocnt_q + LEN_W'(1);
			if (cmd.phase == PH_DIG) num_q <= num_shl;
		end
	end

	always_comb begin
		st.is_dec      = (base_q == BASE_DEC) && !is_char_q;
		st.dabble_last = &step_q;
		st.trim_done   = (ndig_q == LEN_W'(1)) || (top_dig != 4'd0);
		st.cnt_zero    = (cnt_q == '0);
		st.at_last     = (ocnt_q == len_m1_q);
	end

	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule

FILE: rtl/pifmt_ctrl.sv
// ----------------------------------------------------------------------------
// pifmt_ctrl
// Controller of the formatter: walks a conversion through BCD conversion,
// zero digit removal, setup and the five emit phases, and owns both
// handshakes.
// ----------------------------------------------------------------------------
module pifmt_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  pifmt_pkg::pifmt_stat_t  st,
	output pifmt_pkg::pifmt_cmd_t   cmd
);
	import pifmt_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CONV  = 4'd1;
	localparam logic [3:0] S_TRIM  = 4'd2;
	localparam logic [3:0] S_SETUP = 4'd3;
	localparam logic [3:0] S_START = 4'd4;
	localparam logic [3:0] S_LPAD  = 4'd5;
	localparam logic [3:0] S_PFX   = 4'd6;
	localparam logic [3:0] S_ZPAD  = 4'd7;
	localparam logic [3:0] S_DIG   = 4'd8;
	localparam logic [3:0] S_RPAD  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				if (!st.is_dec) begin
					state_d = S_TRIM;
				end else begin
					cmd.dabble = 1'b1;
					if (st.dabble_last) state_d = S_TRIM;
				end
			end
			S_TRIM: begin
				if (st.trim_done) state_d = S_SETUP;
				else cmd.trim = 1'b1;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_START;
			end
			S_START: begin
				cmd.cnt_load = 1'b1;
				cmd.phase    = PH_LPAD;
				state_d      = S_LPAD;
			end
			S_LPAD, S_PFX, S_ZPAD, S_DIG, S_RPAD: begin
				cmd.phase = 3'(state_q - S_LPAD);
				if (st.cnt_zero) begin
					// Phase exhausted: preset the counter of the next one.
					if (state_q == S_RPAD) begin
						state_d = S_IDLE;
					end else begin
						cmd.cnt_load = 1'b1;
						cmd.phase    = 3'(state_q - S_LPAD + 4'd1);
						state_d      = state_q + 4'd1;
					end
				end else if (out_free) begin
					cmd.emit = 1'b1;
					if (st.at_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/printf_integer_field_formatter_core.sv
// ----------------------------------------------------------------------------
// printf_integer_field_formatter_core
// Formats one parsed printf integer conversion into a stream of ASCII
// characters: leading spaces, sign or prefix, zero padding, digits and
// trailing spaces, capped at MAX_FIELD_CHARS characters.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    value, conv_kind, flags, min_width
//   out      source     out_valid/out_ready  out_char, last_char (one char each)
//
// An item passes through capture, conversion and setup, then writes its characters
// one at a time; each leading zero digit removed and each emit phase that runs out
// before the final character takes a step of its own. Decimal conversion runs
// shift-and-add-3 BCD steps, one per operand bit, before leading zero removal.
// A new conversion is taken only once the final character has been written.
// A stalled output holds the emit sequence in place; reset clears only the controller.
// ----------------------------------------------------------------------------
module printf_integer_field_formatter_core #(
	parameter int MAX_FIELD_CHARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value,
	input  logic [2:0]  conv_kind,
	input  logic        long_arg,
	input  logic        alt_form,
	input  logic        zero_fill,
	input  logic        left_justify,
	input  logic        blank_sign,
	input  logic        plus_sign,
	input  logic [6:0]  min_width,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last_char
);
	import pifmt_pkg::*;

	pifmt_cmd_t  cmd;
	pifmt_stat_t st;

	pifmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	pifmt_dp #(
		.MAX_FIELD_CHARS (MAX_FIELD_CHARS)
	) u_dp (
		.clk          (clk),
		.value        (value),
		.conv_kind    (conv_kind),
		.long_arg     (long_arg),
		.alt_form     (alt_form),
		.zero_fill    (zero_fill),
		.left_justify (left_justify),
		.blank_sign   (blank_sign),
		.plus_sign    (plus_sign),
		.min_width    (min_width),
		.cmd          (cmd),
		.st           (st),
		.out_char     (out_char),
		.last_char    (last_char)
	);

	// A character is only written into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("character written over a pending transfer");

	// Datapath steps never overlap.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.dabble, cmd.trim, cmd.setup, cmd.cnt_load, cmd.emit}))
		else $error("more than one datapath command in a cycle");

	// Writing the final character returns the block to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && st.at_last) |=> in_ready)
		else $error("block not idle after the final character");

	// An accepted conversion keeps the input closed on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input reopened right after a transfer");

endmodule

FILE: sim/pifmt_field_checker.sv
// ----------------------------------------------------------------------------
// pifmt_field_checker
// Watches both channels of the printf integer field formatter. Every accepted
// conversion is formatted here into the characters it must produce, and every
// character that leaves the block is compared with the oldest one still owed.
// ----------------------------------------------------------------------------
module pifmt_field_checker #(
	parameter int MAX_FIELD_CHARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] value,
	input  logic [2:0]  conv_kind,
	input  logic        long_arg,
	input  logic        alt_form,
	input  logic        zero_fill,
	input  logic        left_justify,
	input  logic        blank_sign,
	input  logic        plus_sign,
	input  logic [6:0]  min_width,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_char,
	input  logic        last_char,
	output int          mismatches,
	output int          chars_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import pifmt_pkg::*;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} field_char_t;

	field_char_t expected_chars[$];

	// Builds the whole field, then queues at most MAX_FIELD_CHARS characters of it.
	function automatic void format_field(input logic [63:0] v, input logic [2:0] kind,
			input logic is_long, input logic alt, input logic zfill, input logic ljust,
			input logic blank, input logic plus, input logic [6:0] width);
		logic [7:0]  text[$];
		logic [7:0]  pfx[$];
		logic [7:0]  digs[$];
		logic [63:0] mag;
		logic [63:0] radix;
		logic [63:0] d;
		logic [7:0]  alpha;
		int          pad;
		int          n;
		field_char_t fc;
		radix = 64'd10;
		alpha = CH_LOWER_A;
		mag = '0;
		pad = 0;
		if (kind == KIND_CHAR) begin
			pad = (width > 7'd1) ? int'(width) - 1 : 0;
			if (!ljust)
				repeat (pad) text.push_back(CH_SPACE);
			text.push_back(v[7:0]);
			if (ljust)
				repeat (pad) text.push_back(CH_SPACE);
		end else begin
			if (kind == KIND_PTR) begin
				alt = 1'b1;
				is_long = 1'b1;
			end
			if (kind == KIND_SDEC) begin
				if (!is_long)
					v = {{32{v[31]}}, v[31:0]};
				// The negation wraps, so the most negative value keeps its magnitude.
				if (v[63]) begin
					mag = -v;
					pfx.push_back(CH_MINUS);
				end else begin
					mag = v;
					if (blank)
						pfx.push_back(CH_SPACE);
					else if (plus)
						pfx.push_back(CH_PLUS);
				end
			end else begin
				mag = is_long ? v : {32'd0, v[31:0]};
				case (kind)
					KIND_HEX, KIND_UHEX, KIND_PTR: begin
						radix = 64'd16;
						if (kind == KIND_UHEX)
							alpha = CH_UPPER_A;
						if (alt) begin
							pfx.push_back(CH_ZERO);
							pfx.push_back(CH_LOWER_X);
						end
					end
					KIND_OCT: begin
						radix = 64'd8;
						if (alt)
							pfx.push_back(CH_ZERO);
					end
					KIND_BIN: begin
						radix = 64'd2;
						if (alt) begin
							pfx.push_back(CH_ZERO);
							pfx.push_back(CH_LOWER_B);
						end
					end
					default: begin
						if (blank)
							pfx.push_back(CH_SPACE);
						else if (plus)
							pfx.push_back(CH_PLUS);
					end
				endcase
			end
			do begin
				d = mag % radix;
				mag = mag / radix;
				digs.push_front((d < 64'd10) ? CH_ZERO + d[7:0] : alpha + d[7:0] - 8'd10);
			end while (mag != 0 && digs.size() < 64);
			if (int'(width) > pfx.size() + digs.size())
				pad = int'(width) - pfx.size() - digs.size();
			if (!ljust && !zfill)
				repeat (pad) text.push_back(CH_SPACE);
			foreach (pfx[i])
				text.push_back(pfx[i]);
			if (!ljust && zfill)
				repeat (pad) text.push_back(CH_ZERO);
			foreach (digs[i])
				text.push_back(digs[i]);
			if (ljust)
				repeat (pad) text.push_back(CH_SPACE);
		end
		n = (text.size() > MAX_FIELD_CHARS) ? MAX_FIELD_CHARS : text.size();
		for (int i = 0; i < n; i++) begin
			fc.ch = text[i];
			fc.last = (i == n - 1);
			expected_chars.push_back(fc);
		end
	endfunction

	always @(posedge clk) begin
		field_char_t want;
		if (arst_n) begin
			// Outputs are compared before the new conversion is queued, since a
			// character in this cycle can never belong to it.
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected out transfer: out_char %h, last_char %b",
						out_char, last_char);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (out_char !== want.ch) begin
						$error("out_char: expected %h, got %h", want.ch, out_char);
						mismatches++;
					end
					if (last_char !== want.last) begin
						$error("last_char: expected %b, got %b", want.last, last_char);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				format_field(value, conv_kind, long_arg, alt_form, zero_fill,
					left_justify, blank_sign, plus_sign, min_width);
			chars_owed = expected_chars.size();
		end
	end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives parsed printf conversions into the integer field formatter: a short
// directed set of corner cases, then random conversions in phases with and
// without idle cycles on the input side and stalls on the output side.
// The checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pifmt_pkg::*;

	typedef struct {
		logic [63:0] value;
		logic [2:0]  kind;
		logic        is_long;
		logic        alt;
		logic        zfill;
		logic        ljust;
		logic        blank;
		logic        plus;
		logic [6:0]  width;
	} conv_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] value = '0;
	logic [2:0]  conv_kind = KIND_SDEC;
	logic        long_arg = 1'b0;
	logic        alt_form = 1'b0;
	logic        zero_fill = 1'b0;
	logic        left_justify = 1'b0;
	logic        blank_sign = 1'b0;
	logic        plus_sign = 1'b0;
	logic [6:0]  min_width = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_char;
	logic        last_char;

	int mismatches;
	int chars_owed;
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	int stall_left = 0;

	always #6 clk = ~clk;

	printf_integer_field_formatter_core #(.MAX_FIELD_CHARS(64)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value(value), .conv_kind(conv_kind), .long_arg(long_arg),
		.alt_form(alt_form), .zero_fill(zero_fill),
		.left_justify(left_justify), .blank_sign(blank_sign),
		.plus_sign(plus_sign), .min_width(min_width),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_char(out_char), .last_char(last_char)
	);

	pifmt_field_checker #(.MAX_FIELD_CHARS(64)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value(value), .conv_kind(conv_kind), .long_arg(long_arg),
		.alt_form(alt_form), .zero_fill(zero_fill),
		.left_justify(left_justify), .blank_sign(blank_sign),
		.plus_sign(plus_sign), .min_width(min_width),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_char(out_char), .last_char(last_char),
		.mismatches(mismatches), .chars_owed(chars_owed)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		int len;
		if (!arst_n || sink_steady) begin
			out_ready <= arst_n;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			len = pick_gap();
			out_ready <= (len == 0);
			stall_left <= (len > 0) ? len - 1 : 0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic conv_req_t mk(input logic [63:0] v, input logic [2:0] k,
			input logic lng, input logic alt, input logic zf, input logic lj,
			input logic bl, input logic pl, input logic [6:0] w);
		conv_req_t c;
		c.value = v;
		c.kind = k;
		c.is_long = lng;
		c.alt = alt;
		c.zfill = zf;
		c.ljust = lj;
		c.blank = bl;
		c.plus = pl;
		c.width = w;
		return c;
	endfunction

	function automatic conv_req_t rand_conv();
		conv_req_t c;
		int r;
		case ($urandom_range(0, 5))
			0: c.value = 64'($urandom_range(0, 20));
			1, 2: c.value = {$urandom, $urandom};
			3: begin
				case ($urandom_range(0, 6))
					0: c.value = '0;
					1: c.value = '1;
					2: c.value = 64'h8000_0000_0000_0000;
					3: c.value = 64'h7fff_ffff_ffff_ffff;
					4: c.value = {$urandom, 32'h8000_0000};
					5: c.value = {$urandom, 32'hffff_ffff};
					default: c.value = {$urandom, 32'h7fff_ffff};
				endcase
			end
			4: c.value = {$urandom, 32'hffff_ffff - 32'($urandom_range(0, 300))};
			default: c.value = $urandom_range(0, 1) ? (64'd1 << $urandom_range(0, 63))
				: ('1 >> $urandom_range(0, 63));
		endcase
		c.kind = 3'($urandom_range(0, 7));
		c.is_long = 1'($urandom_range(0, 1));
		c.alt = 1'($urandom_range(0, 1));
		c.zfill = 1'($urandom_range(0, 1));
		c.ljust = 1'($urandom_range(0, 1));
		c.blank = 1'($urandom_range(0, 1));
		c.plus = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 70)
			c.width = 7'($urandom_range(0, 16));
		else if (r < 92)
			c.width = 7'($urandom_range(17, 64));
		else
			c.width = 7'($urandom_range(65, 127));
		return c;
	endfunction

	// Presents one conversion and returns in the time step of its transfer.
	task automatic send_conv(input conv_req_t c);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= c.value;
		conv_kind <= c.kind;
		long_arg <= c.is_long;
		alt_form <= c.alt;
		zero_fill <= c.zfill;
		left_justify <= c.ljust;
		blank_sign <= c.blank;
		plus_sign <= c.plus;
		min_width <= c.width;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Holds the input off until every owed character has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (chars_owed != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_conv(rand_conv());
	endtask

	initial begin
		#(50_000_000);
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Signed decimal corners, including the most negative 32- and 64-bit values.
		send_conv(mk(64'h1234_5678_8000_0000, KIND_SDEC, 0, 0, 0, 0, 0, 0, 0));
		send_conv(mk(64'h8000_0000_0000_0000, KIND_SDEC, 1, 0, 0, 0, 0, 0, 0));
		send_conv(mk(64'hffff_ffff_7fff_ffff, KIND_SDEC, 0, 0, 0, 0, 1, 1, 12));
		send_conv(mk(64'd42, KIND_SDEC, 0, 0, 1, 0, 0, 1, 10));
		send_conv(mk(64'hffff_ffff_ffff_fffb, KIND_SDEC, 1, 0, 1, 1, 0, 0, 8));
		// Unsigned decimal takes the sign flags too.
		send_conv(mk('1, KIND_UDEC, 1, 0, 0, 0, 1, 0, 0));
		send_conv(mk(64'd0, KIND_UDEC, 0, 0, 0, 1, 0, 1, 5));
		send_conv(mk(64'hffff_ffff_ffff_ffff, KIND_UDEC, 0, 1, 1, 0, 0, 0, 64));
		// Hex: upper case digits keep the lower case prefix; high half dropped.
		send_conv(mk(64'hcafe_0000_dead_beef, KIND_HEX, 0, 1, 1, 0, 0, 0, 12));
		send_conv(mk(64'hfedc_ba98_7654_3210, KIND_UHEX, 1, 1, 0, 0, 1, 1, 20));
		send_conv(mk(64'h0, KIND_HEX, 1, 1, 0, 1, 0, 0, 64));
		// Octal zero with the alternate form prints two zeros.
		send_conv(mk(64'h5555_5555_0000_0000, KIND_OCT, 0, 1, 0, 0, 0, 0, 0));
		send_conv(mk('1, KIND_OCT, 1, 1, 1, 0, 0, 0, 30));
		// A binary field with prefix runs past the cap and is cut.
		send_conv(mk('1, KIND_BIN, 1, 1, 0, 0, 0, 0, 0));
		send_conv(mk(64'h0, KIND_BIN, 1, 0, 1, 0, 1, 1, 64));
		send_conv(mk(64'h8000_0000_0000_0001, KIND_BIN, 1, 1, 1, 0, 0, 0, 127));
		// Characters ignore zero fill, sign flags and the alternate form.
		send_conv(mk(64'hffff_ffff_ffff_ff41, KIND_CHAR, 1, 1, 1, 0, 1, 1, 5));
		send_conv(mk(64'h0000_0000_0000_00ff, KIND_CHAR, 0, 0, 1, 1, 0, 0, 64));
		send_conv(mk(64'h0, KIND_CHAR, 0, 0, 0, 0, 0, 0, 0));
		// Pointers always print as long lower case hex with prefix.
		send_conv(mk(64'h0, KIND_PTR, 0, 0, 0, 0, 0, 0, 0));
		send_conv(mk('1, KIND_PTR, 0, 0, 1, 1, 1, 1, 20));
		send_conv(mk(64'h0000_0001_0000_0000, KIND_PTR, 0, 0, 1, 0, 0, 0, 127));
		send_conv(mk(64'd7, KIND_SDEC, 1, 0, 1, 0, 0, 0, 100));
		wait_drained();

		// Back to back, no stalls anywhere.
		src_steady = 1'b1;
		sink_steady = 1'b1;
		send_random(80);
		wait_drained();

		// Idle cycles and stalls on both sides.
		src_steady = 1'b0;
		sink_steady = 1'b0;
		send_random(80);
		wait_drained();

		// Steady input against a stalling output.
		src_steady = 1'b1;
		send_random(77);
		wait_drained();

		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: printf_integer_field_formatter_core.f
rtl/pifmt_pkg.sv
rtl/pifmt_dp.sv
rtl/pifmt_ctrl.sv
rtl/printf_integer_field_formatter_core.sv
sim/pifmt_field_checker.sv
sim/tb.sv
